// ===== design/abrd_pkg.sv =====
`default_nettype none

package abrd_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned WORD_W   = 2 * SAMPLE_W;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned BIU_W    = 5;
  localparam int unsigned FPB_W    = 7;
  localparam int unsigned CFG_W    = FPB_W;

  localparam logic [BIU_W-1:0] BIU_RESET = 5'd16;
  localparam logic [FPB_W-1:0] FPB_RESET = 7'd64;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } abrd_op_e;

  typedef enum logic {
    CFG_BLOCKS_IN_USE    = 1'b0,
    CFG_FRAMES_PER_BLOCK = 1'b1
  } abrd_cfg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_PULL = 1'b1
  } abrd_state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } abrd_mem_ctl_t;

endpackage

`default_nettype wire

// ===== design/abrd_store.sv =====
`default_nettype none

module abrd_store import abrd_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic              clk_i,
  input  wire abrd_mem_ctl_t     mem_ctl_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [WORD_W-1:0] wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold the read word while the output stalls
  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/abrd_ctrl.sv =====
`default_nettype none

module abrd_ctrl import abrd_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned MAX_FRAMES = 64,
  parameter int unsigned BW         = 4,
  parameter int unsigned FW         = 6,
  parameter int unsigned AW         = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               in_op_i,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_index_i,
  input  wire logic [CFG_W-1:0]   cfg_data_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic                    out_last_o,
  output logic                    out_from_o,
  output logic      [BIU_W-1:0]   out_avail_o,
  output logic      [TOTAL_W-1:0] out_overrun_o,
  output logic      [TOTAL_W-1:0] out_underrun_o,
  output logic      [TOTAL_W-1:0] out_produced_o,
  output logic      [TOTAL_W-1:0] out_consumed_o,
  output abrd_mem_ctl_t           mem_ctl_o,
  output logic      [AW-1:0]      waddr_o,
  output logic      [AW-1:0]      raddr_o
);

  abrd_state_e state_q, state_d;

  logic [BIU_W-1:0]   biu_q, biu_d;
  logic [FPB_W-1:0]   fpb_q, fpb_d;
  logic [BW-1:0]      head_q, head_d;
  logic [BW-1:0]      tail_q, tail_d;
  logic [BIU_W-1:0]   count_q, count_d;
  logic [FW-1:0]      wpos_q, wpos_d;
  logic [TOTAL_W-1:0] ovr_q, ovr_d;
  logic [TOTAL_W-1:0] und_q, und_d;
  logic [TOTAL_W-1:0] prod_q, prod_d;
  logic [TOTAL_W-1:0] cons_q, cons_d;
  logic [BW-1:0]      rblk_q, rblk_d;
  logic [FW-1:0]      rpos_q, rpos_d;
  logic               have_q, have_d;

  logic               out_valid_q;
  logic               out_last_q;
  logic               out_from_q;
  logic [BIU_W-1:0]   out_avail_q;
  logic [TOTAL_W-1:0] out_ovr_q;
  logic [TOTAL_W-1:0] out_und_q;
  logic [TOTAL_W-1:0] out_prod_q;
  logic [TOTAL_W-1:0] out_cons_q;

  logic [BIU_W-1:0] nb;
  logic [FPB_W-1:0] nf;
  logic             in_acc;
  logic             push_acc;
  logic             pull_acc;
  logic             issue;
  logic             adv;
  logic             fire;
  logic             last_beat;
  logic             drop;
  logic             commit;
  logic             have;

  always_comb begin
    if (int'(biu_q) > int'(MAX_BLOCKS)) begin
      nb = BIU_W'(MAX_BLOCKS);
    end else begin
      nb = biu_q;
    end
    if (fpb_q == '0) begin
      nf = FPB_W'(1);
    end else if (int'(fpb_q) > int'(MAX_FRAMES)) begin
      nf = FPB_W'(MAX_FRAMES);
    end else begin
      nf = fpb_q;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign push_acc   = in_acc && (in_op_i == OP_PUSH) && (nb != '0);
  assign pull_acc   = in_acc && (in_op_i == OP_PULL);
  assign issue      = (state_q == ST_PULL);
  assign adv        = !out_valid_q || out_ready_i;
  assign fire       = issue && adv;
  assign last_beat  = (int'(rpos_q) + 1 == int'(nf));
  assign drop       = push_acc && (wpos_q == '0) && (count_q >= nb);
  assign commit     = push_acc && (int'(wpos_q) + 1 == int'(nf));
  assign have       = (count_q != '0) && (nb != '0);

  assign mem_ctl_o.wr_en = push_acc;
  assign mem_ctl_o.rd_en = fire;
  assign waddr_o = AW'(int'(head_q) * int'(MAX_FRAMES) + int'(wpos_q));
  assign raddr_o = AW'(int'(rblk_q) * int'(MAX_FRAMES) + int'(rpos_q));

  always_comb begin
    state_d = state_q;
    biu_d   = biu_q;
    fpb_d   = fpb_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    wpos_d  = wpos_q;
    ovr_d   = ovr_q;
    und_d   = und_q;
    prod_d  = prod_q;
    cons_d  = cons_q;
    rblk_d  = rblk_q;
    rpos_d  = rpos_q;
    have_d  = have_q;

    if (cfg_valid_i) begin
      unique case (abrd_cfg_e'(cfg_index_i))
        CFG_BLOCKS_IN_USE:    biu_d = cfg_data_i[BIU_W-1:0];
        CFG_FRAMES_PER_BLOCK: fpb_d = cfg_data_i[FPB_W-1:0];
        default: ;
      endcase
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
      wpos_d  = '0;
    end

    if (push_acc) begin
      if (drop) begin
        tail_d = (int'(tail_q) + 1 == int'(nb)) ? '0 : BW'(int'(tail_q) + 1);
        ovr_d  = ovr_q + 1'b1;
      end
      if (commit) begin
        wpos_d = '0;
        head_d = (int'(head_q) + 1 == int'(nb)) ? '0 : BW'(int'(head_q) + 1);
        prod_d = prod_q + 1'b1;
      end else begin
        wpos_d = FW'(int'(wpos_q) + 1);
      end
      count_d = BIU_W'(int'(count_q) - int'(drop) + int'(commit));
    end

    unique case (state_q)
      ST_IDLE: begin
        if (pull_acc) begin
          rblk_d  = tail_q;
          rpos_d  = '0;
          have_d  = have;
          state_d = ST_PULL;
          if (have) begin
            tail_d  = (int'(tail_q) + 1 == int'(nb)) ? '0 : BW'(int'(tail_q) + 1);
            count_d = count_q - 1'b1;
            cons_d  = cons_q + 1'b1;
          end else begin
            und_d = und_q + 1'b1;
          end
        end
      end
      ST_PULL: begin
        if (fire) begin
          rpos_d = FW'(int'(rpos_q) + 1);
          if (last_beat) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      biu_q       <= BIU_RESET;
      fpb_q       <= FPB_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      wpos_q      <= '0;
      ovr_q       <= '0;
      und_q       <= '0;
      prod_q      <= '0;
      cons_q      <= '0;
      rblk_q      <= '0;
      rpos_q      <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      biu_q   <= biu_d;
      fpb_q   <= fpb_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      wpos_q  <= wpos_d;
      ovr_q   <= ovr_d;
      und_q   <= und_d;
      prod_q  <= prod_d;
      cons_q  <= cons_d;
      rblk_q  <= rblk_d;
      rpos_q  <= rpos_d;
      have_q  <= have_d;
      if (adv) begin
        out_valid_q <= issue;
      end
    end
  end

  // capture the word's flags and totals as it enters the output stage
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_last_q  <= last_beat;
      out_from_q  <= have_q;
      out_avail_q <= count_q;
      out_ovr_q   <= ovr_q;
      out_und_q   <= und_q;
      out_prod_q  <= prod_q;
      out_cons_q  <= cons_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_last_o     = out_last_q;
  assign out_from_o     = out_from_q;
  assign out_avail_o    = out_avail_q;
  assign out_overrun_o  = out_ovr_q;
  assign out_underrun_o = out_und_q;
  assign out_produced_o = out_prod_q;
  assign out_consumed_o = out_cons_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= nb)
    else $error("block count above ring size");

  a_no_write_in_pull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(issue && mem_ctl_o.wr_en))
    else $error("store written while a block streams out");

  a_last_ends_pull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last_beat) |=> (state_q == ST_IDLE))
    else $error("pull did not end on its last frame");

  a_wpos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(wpos_q) < int'(nf))
    else $error("write frame position beyond block");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_last_q)))
    else $error("output word changed under stall");

endmodule

`default_nettype wire

// ===== design/audio_block_ring_drop_oldest.sv =====
// Push: one word per cycle, accepted whenever no pull is streaming; no result.
// Pull: streams frames_per_block result words, one per cycle when the sink is ready,
//   first word valid after the pull state reads it; next input taken after last read.
// Throughput set by the single read port of the sample memory and the pull sequencer.
// Reset: ring empty, totals zero, blocks_in_use 16, frames_per_block 64; the sample
//   memory is not cleared and needs no clearing pass.
`default_nettype none

module audio_block_ring_drop_oldest import abrd_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned MAX_FRAMES = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // left_in [15:0], right_in [31:16]
  input  wire logic [31:0]        s_axis_tdata,
  // operation [0]
  input  wire logic               s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // left_out [15:0], right_out [31:16], blocks_available [36:32],
  // overrun_total [68:37], underrun_total [100:69], produced_total [132:101],
  // consumed_total [164:133], zero [167:165]
  output logic      [167:0]       m_axis_tdata,
  output logic                    m_axis_tlast,
  // from_buffer [0]
  output logic                    m_axis_tuser,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_index_i,
  input  wire logic [CFG_W-1:0]   cfg_data_i
);

  localparam int unsigned BW    = $clog2(MAX_BLOCKS);
  localparam int unsigned FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned DEPTH = MAX_BLOCKS * MAX_FRAMES;
  localparam int unsigned AW    = $clog2(DEPTH);

  abrd_mem_ctl_t      mem_ctl;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [WORD_W-1:0]  rdata;
  logic               out_from;
  logic [BIU_W-1:0]   out_avail;
  logic [TOTAL_W-1:0] out_ovr;
  logic [TOTAL_W-1:0] out_und;
  logic [TOTAL_W-1:0] out_prod;
  logic [TOTAL_W-1:0] out_cons;
  logic [WORD_W-1:0]  out_word;

  assign cfg_ready_o = 1'b1;

  abrd_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .MAX_FRAMES (MAX_FRAMES),
    .BW         (BW),
    .FW         (FW),
    .AW         (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_op_i        (s_axis_tuser),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_last_o     (m_axis_tlast),
    .out_from_o     (out_from),
    .out_avail_o    (out_avail),
    .out_overrun_o  (out_ovr),
    .out_underrun_o (out_und),
    .out_produced_o (out_prod),
    .out_consumed_o (out_cons),
    .mem_ctl_o      (mem_ctl),
    .waddr_o        (waddr),
    .raddr_o        (raddr)
  );

  abrd_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .mem_ctl_i (mem_ctl),
    .waddr_i   (waddr),
    .wdata_i   (s_axis_tdata[WORD_W-1:0]),
    .raddr_i   (raddr),
    .rdata_o   (rdata)
  );

  // silence when the ring was empty
  assign out_word     = out_from ? rdata : '0;
  assign m_axis_tuser = out_from;
  assign m_axis_tdata = {3'b000, out_cons, out_prod, out_und, out_ovr, out_avail, out_word};

endmodule

`default_nettype wire
